/* rtl/nsp_pkg.sv */
// ----------------------------------------------------------------------------
// nsp_pkg - shared types and constants for the nearest seed pixel color block
// Seed register layout, candidate record and the tie-aware pick function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nsp_pkg;

    localparam int MAX_SITES  = 8;
    localparam int IDX_W      = 3;
    localparam int ROW_W      = 10;
    localparam int COL_W      = 9;
    localparam int COLOR_W    = 8;
    localparam int DIST_W     = 20;
    localparam int SEED_W     = 43;
    localparam int CFG_IDX_W  = 4;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 32;

    // packed seed register, MSB first: blue, green, red, y, x
    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic [ROW_W-1:0]   y;
        logic [COL_W-1:0]   x;
    } seed_t;

    typedef struct packed {
        logic [DIST_W-1:0] dsq;
        logic [IDX_W-1:0]  idx;
        logic              act;
    } cand_t;

    // a always holds the lower seed index, so it wins ties
    function automatic cand_t pick_near(input cand_t a, input cand_t b);
        cand_t r;
        if (a.act && (!b.act || (a.dsq <= b.dsq))) begin
            r = a;
        end else begin
            r = b;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/nearest_seed_pixel_color.sv */
// ----------------------------------------------------------------------------
// nearest_seed_pixel_color - Voronoi cell color lookup, Euclidean metric
// Returns the color and index of the seed nearest to each pixel coordinate.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the sink does not stall; every stage holds its own valid bit, so a
//   bubble anywhere lets the input side keep accepting while a result waits.
// Reset: aresetn (synchronous, active low) clears all stage valid bits and
//   sets every seed register to zero. Data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module nearest_seed_pixel_color #(
    parameter int NUM_SITES = 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    // pixel coordinates in
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [nsp_pkg::S_DATA_W-1:0]   s_tdata,   // [9:0] row, [18:10] col, pad

    // color result out
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [nsp_pkg::M_DATA_W-1:0]        m_tdata,   // [7:0] red, [15:8] green,
                                                           // [23:16] blue, [26:24] nearest

    // seed register writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [nsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [nsp_pkg::SEED_W-1:0]     cfg_data
);

    localparam int SITE_W = (NUM_SITES > 1) ? $clog2(NUM_SITES) : 1;

    // ------------------------------------------------------------------
    // Seed registers. Writes to indexes at or above NUM_SITES are dropped.
    // ------------------------------------------------------------------
    nsp_pkg::seed_t seed_reg [NUM_SITES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SITES; i++) begin
                seed_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready && (32'(cfg_index) < NUM_SITES)) begin
            seed_reg[cfg_index[SITE_W-1:0]] <= nsp_pkg::seed_t'(cfg_data);
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. A stage loads when it is empty or when the
    // stage after it loads; a held stage keeps its data and valid bit.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic adv1, adv2, adv3, adv4, adv5, adv6;

    assign adv6     = !v6_reg || m_tready;
    assign adv5     = !v5_reg || adv6;
    assign adv4     = !v4_reg || adv5;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_tvalid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
            if (adv6) v6_reg <= v5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: per-seed absolute differences |row - y|, |col - x|.
    // ------------------------------------------------------------------
    logic [nsp_pkg::ROW_W-1:0] row_in;
    logic [nsp_pkg::COL_W-1:0] col_in;
    logic [nsp_pkg::ROW_W-1:0] dy_reg  [NUM_SITES];
    logic [nsp_pkg::COL_W-1:0] dx_reg  [NUM_SITES];
    logic [nsp_pkg::ROW_W-1:0] dy_next [NUM_SITES];
    logic [nsp_pkg::COL_W-1:0] dx_next [NUM_SITES];

    assign row_in = s_tdata[nsp_pkg::ROW_W-1:0];
    assign col_in = s_tdata[nsp_pkg::ROW_W +: nsp_pkg::COL_W];

    always_comb begin
        for (int i = 0; i < NUM_SITES; i++) begin
            dy_next[i] = (row_in >= seed_reg[i].y) ? (row_in - seed_reg[i].y)
                                                   : (seed_reg[i].y - row_in);
            dx_next[i] = (col_in >= seed_reg[i].x) ? (col_in - seed_reg[i].x)
                                                   : (seed_reg[i].x - col_in);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares (10x10 and 9x9 multipliers per seed).
    // Stage 3: sum, saturated to 20 bits.
    // ------------------------------------------------------------------
    logic [nsp_pkg::DIST_W-1:0]   sqy_reg  [NUM_SITES];
    logic [nsp_pkg::DIST_W-3:0]   sqx_reg  [NUM_SITES];
    logic [nsp_pkg::DIST_W-1:0]   dist_reg [NUM_SITES];
    logic [nsp_pkg::DIST_W-1:0]   dist_next[NUM_SITES];
    logic [nsp_pkg::DIST_W:0]     dsum     [NUM_SITES];

    always_comb begin
        for (int i = 0; i < NUM_SITES; i++) begin
            dsum[i]      = (nsp_pkg::DIST_W+1)'(sqy_reg[i]) + (nsp_pkg::DIST_W+1)'(sqx_reg[i]);
            dist_next[i] = dsum[i][nsp_pkg::DIST_W] ? '1 : dsum[i][nsp_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_SITES; i++) begin
            if (adv1) begin
                dy_reg[i] <= dy_next[i];
                dx_reg[i] <= dx_next[i];
            end
            if (adv2) begin
                sqy_reg[i] <= nsp_pkg::DIST_W'(dy_reg[i]) * nsp_pkg::DIST_W'(dy_reg[i]);
                sqx_reg[i] <= (nsp_pkg::DIST_W-2)'(dx_reg[i])
                            * (nsp_pkg::DIST_W-2)'(dx_reg[i]);
            end
            if (adv3) begin
                dist_reg[i] <= dist_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 4..6: registered min tree 8 -> 4 -> 2 -> 1. Slots at or
    // above NUM_SITES are inactive and never win. The left operand always
    // carries the lower index, which gives lowest-index tie breaking.
    // ------------------------------------------------------------------
    nsp_pkg::cand_t c3 [nsp_pkg::MAX_SITES];
    nsp_pkg::cand_t st4_reg [nsp_pkg::MAX_SITES/2];
    nsp_pkg::cand_t st5_reg [nsp_pkg::MAX_SITES/4];
    nsp_pkg::cand_t fin;
    nsp_pkg::seed_t win_seed;

    for (genvar i = 0; i < nsp_pkg::MAX_SITES; i++) begin : g_cand
        if (i < NUM_SITES) begin : g_on
            assign c3[i].dsq = dist_reg[i];
            assign c3[i].act = 1'b1;
        end else begin : g_off
            assign c3[i].dsq = '0;
            assign c3[i].act = 1'b0;
        end
        assign c3[i].idx = 3'(i);
    end

    assign fin      = nsp_pkg::pick_near(st5_reg[0], st5_reg[1]);
    assign win_seed = seed_reg[fin.idx[SITE_W-1:0]];

    logic [nsp_pkg::M_DATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (adv4) begin
            for (int j = 0; j < nsp_pkg::MAX_SITES/2; j++) begin
                st4_reg[j] <= nsp_pkg::pick_near(c3[2*j], c3[2*j+1]);
            end
        end
        if (adv5) begin
            for (int k = 0; k < nsp_pkg::MAX_SITES/4; k++) begin
                st5_reg[k] <= nsp_pkg::pick_near(st4_reg[2*k], st4_reg[2*k+1]);
            end
        end
        if (adv6) begin
            m_tdata_reg <= {5'b0, fin.idx, win_seed.blue, win_seed.green, win_seed.red};
        end
    end

    assign m_tvalid = v6_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // the reported seed is always one that exists
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[26:24]) < NUM_SITES))
        else $error("nearest index beyond NUM_SITES");

    // input backpressure only when every stage is full and the sink stalls
    a_no_early_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && v6_reg
                       && !m_tready))
        else $error("input stalled with a bubble in the pipeline");

    // a held distance stage keeps its data
    a_hold_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !adv3) |=> (v3_reg && $stable(dist_reg[0])))
        else $error("stage 3 lost or changed a held item");

    // a held tree stage keeps its winner
    a_hold_tree: assert property (@(posedge aclk) disable iff (!aresetn)
        (v5_reg && !adv5) |=> (v5_reg && $stable(st5_reg[0]) && $stable(st5_reg[1])))
        else $error("stage 5 lost or changed a held item");
`endif

endmodule

`default_nettype wire

/* tb/tb_nearest_seed_pixel_color.sv */
// ----------------------------------------------------------------------------
// tb_nearest_seed_pixel_color - self-checking bench for the Voronoi color lookup
// Streams pixel coordinates through the block under several seed tables and
// checks each returned color and seed index against an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nearest_seed_pixel_color;

    import nsp_pkg::*;

    // quiet-cycle limit: well above the long sink hold plus the longest gaps
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int LONG_HOLD_CYCLES = 400;
    // cycles to watch for stray results once everything has come back
    localparam int DRAIN_CYCLES     = 24;
    localparam int REPORT_LIMIT     = 10;
    localparam int unsigned DIST_SAT = (1 << DIST_W) - 1;

    // writes to these indexes fall outside the seed table and must be dropped
    localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_REG = CFG_IDX_W'(MAX_SITES);
    localparam logic [CFG_IDX_W-1:0] LAST_SPARE_REG  = '1;

    // pixel item, laid out exactly as s_tdata (row in the low bits)
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } pixel_t;

    // result item, laid out exactly as m_tdata[26:0]
    typedef struct packed {
        logic [IDX_W-1:0]   nearest;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } color_t;

    // how a whole seed table is filled for one phase
    typedef enum int {
        SEEDS_IMAGE,    // positions inside the image, random colors
        SEEDS_RANDOM,   // every register bit random, positions may leave the image
        SEEDS_CLUSTER,  // all seeds packed near the origin, far pixels saturate
        SEEDS_SAME,     // one shared position, every pixel is an eight-way tie
        SEEDS_ALL_ONES, // every register bit set
        SEEDS_ZERO      // every register bit clear
    } seed_style_e;

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;   // [9:0] row, [18:10] col, pad
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;          // [7:0] red, [15:8] green,
                                            // [23:16] blue, [26:24] nearest
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SEED_W-1:0]    cfg_data  = '0;

    nearest_seed_pixel_color dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    seed_t  seed_bank [MAX_SITES];  // our copy of the seed table
    pixel_t pixel_q [$];            // pixels waiting for the driver
    color_t color_due_q [$];        // predicted colors, oldest first

    int pixels_queued  = 0;         // pixels handed to the driver so far
    int colors_checked = 0;         // results matched against a prediction
    int err_count      = 0;

    bit sender_idle = 1'b0;         // random gaps on the pixel side
    bit sink_idle   = 1'b0;         // random stalls on the result side
    int hold_requests = 0;          // bumped to ask the sink for a long hold
    int hold_served   = 0;

    int send_gap  = 0;
    int sink_gap  = 0;
    int sink_hold = 0;
    int idle_cycles = 0;

    pixel_t drv_pix;
    color_t mon_got;
    color_t mon_exp;

    // ------------------------------------------------------------------------
    // Predictor: squared Euclidean distance, saturated at the 20-bit max,
    // strict less-than so a tie keeps the lower seed index
    // ------------------------------------------------------------------------
    function automatic color_t nearest_color(input pixel_t pix);
        int unsigned dy;
        int unsigned dx;
        int unsigned d;
        int unsigned best_d;
        int          best;
        color_t      res;
        best   = 0;
        best_d = DIST_SAT + 1;
        for (int s = 0; s < MAX_SITES; s++) begin
            dy = (pix.row >= seed_bank[s].y) ? pix.row - seed_bank[s].y
                                             : seed_bank[s].y - pix.row;
            dx = (pix.col >= seed_bank[s].x) ? pix.col - seed_bank[s].x
                                             : seed_bank[s].x - pix.col;
            d  = dy * dy + dx * dx;
            if (d > DIST_SAT) begin
                d = DIST_SAT;
            end
            if (d < best_d) begin
                best_d = d;
                best   = s;
            end
        end
        res.red     = seed_bank[best].red;
        res.green   = seed_bank[best].green;
        res.blue    = seed_bank[best].blue;
        res.nearest = IDX_W'(best);
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 80);
    endfunction

    function automatic seed_t seed_at(input int x, input int y,
                                      input int r, input int g, input int b);
        seed_t sd;
        sd.x     = COL_W'(x);
        sd.y     = ROW_W'(y);
        sd.red   = COLOR_W'(r);
        sd.green = COLOR_W'(g);
        sd.blue  = COLOR_W'(b);
        return sd;
    endfunction

    // pixel mix: plain image pixels, full 10-bit rows, pixels hugging a seed,
    // and midpoints between two seeds (where distance ties are likely)
    function automatic pixel_t make_pixel();
        pixel_t pix;
        int     r;
        int     a;
        int     b;
        r = $urandom_range(0, 99);
        a = $urandom_range(0, MAX_SITES - 1);
        b = $urandom_range(0, MAX_SITES - 1);
        if (r < 40) begin
            pix.row = ROW_W'($urandom_range(0, 767));
            pix.col = COL_W'($urandom_range(0, 511));
        end else if (r < 60) begin
            pix.row = ROW_W'($urandom_range(0, 1023));
            pix.col = COL_W'($urandom_range(0, 511));
        end else if (r < 80) begin
            // offsets wrap at the field widths on purpose
            pix.row = seed_bank[a].y + ROW_W'($urandom_range(0, 6) - 3);
            pix.col = seed_bank[a].x + COL_W'($urandom_range(0, 6) - 3);
        end else begin
            pix.row = ROW_W'((int'(seed_bank[a].y) + int'(seed_bank[b].y)) / 2);
            pix.col = COL_W'((int'(seed_bank[a].x) + int'(seed_bank[b].x)) / 2);
        end
        return pix;
    endfunction

    function automatic seed_t make_seed(input seed_style_e style, input seed_t shared);
        logic [63:0] wide;
        seed_t       sd;
        wide = {$urandom(), $urandom()};
        sd   = seed_t'(wide[SEED_W-1:0]);
        case (style)
            SEEDS_IMAGE: begin
                sd.x = COL_W'($urandom_range(0, 511));
                sd.y = ROW_W'($urandom_range(0, 767));
            end
            SEEDS_CLUSTER: begin
                sd.x = COL_W'($urandom_range(0, 3));
                sd.y = ROW_W'($urandom_range(0, 3));
            end
            SEEDS_SAME: begin
                sd.x = shared.x;
                sd.y = shared.y;
            end
            SEEDS_ALL_ONES: begin
                sd = '1;
            end
            SEEDS_ZERO: begin
                sd = '0;
            end
            default: begin
            end
        endcase
        return sd;
    endfunction

    // ------------------------------------------------------------------------
    // Config writes, called from the stimulus thread in step with aclk.
    // cfg_valid is left high so back-to-back writes never toggle it in one step.
    // ------------------------------------------------------------------------
    task automatic write_seed(input logic [CFG_IDX_W-1:0] idx, input seed_t val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        if (idx < MAX_SITES) begin
            seed_bank[idx] = val;
        end
    endtask

    task automatic load_seeds(input seed_style_e style);
        seed_t shared;
        shared = make_seed(SEEDS_RANDOM, '0);
        for (int i = 0; i < MAX_SITES; i++) begin
            write_seed(CFG_IDX_W'(i), make_seed(style, shared));
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_pixel(input int row, input int col);
        pixel_t pix;
        pix.row = ROW_W'(row);
        pix.col = COL_W'(col);
        pixel_q.push_back(pix);
        pixels_queued++;
    endtask

    // block is idle once every queued pixel has come back as a color
    task automatic wait_idle();
        while (colors_checked != pixels_queued) begin
            @(posedge aclk);
        end
    endtask

    task automatic run_phase(input seed_style_e style, input int count,
                             input bit gaps, input bit long_hold);
        load_seeds(style);
        sender_idle = gaps;
        sink_idle   = gaps;
        if (long_hold) begin
            hold_requests++;
        end
        for (int i = 0; i < count; i++) begin
            pixel_q.push_back(make_pixel());
            pixels_queued++;
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Pixel driver: hold the item while stalled, otherwise gap or send next.
    // The prediction is taken at the accepting edge, with the current table.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                color_due_q.push_back(nearest_color(pixel_t'(s_tdata[ROW_W+COL_W-1:0])));
            end
            if (s_tvalid && !s_tready) begin
                // item stays on the bus until taken
            end else if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                drv_pix = pixel_q.pop_front();
                s_tdata  <= S_DATA_W'(drv_pix);
                s_tvalid <= 1'b1;
                send_gap = sender_idle ? pick_gap() : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: long hold on request (fills the pipe and backs up s_tready),
    // random stalls when enabled, else always ready
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap  = 0;
            sink_hold = 0;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            sink_hold   = LONG_HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold--;
            m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (sink_idle && $urandom_range(0, 3) == 0) begin
                sink_gap = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: each accepted result against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            mon_got = color_t'(m_tdata[$bits(color_t)-1:0]);
            if (color_due_q.size() == 0) begin
                err_count++;
                if (err_count <= REPORT_LIMIT) begin
                    $display("[%0t] unexpected result: r=%0d g=%0d b=%0d idx=%0d", $realtime,
                             mon_got.red, mon_got.green, mon_got.blue, mon_got.nearest);
                end
            end else begin
                mon_exp = color_due_q.pop_front();
                colors_checked++;
                if (mon_got.red !== mon_exp.red || mon_got.green !== mon_exp.green ||
                    mon_got.blue !== mon_exp.blue || mon_got.nearest !== mon_exp.nearest)
                begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT) begin
                        $display("[%0t] mismatch: exp r=%0d g=%0d b=%0d idx=%0d, got r=%0d g=%0d b=%0d idx=%0d",
                                 $realtime, mon_exp.red, mon_exp.green, mon_exp.blue,
                                 mon_exp.nearest, mon_got.red, mon_got.green,
                                 mon_got.blue, mon_got.nearest);
                    end
                end
            end
        end
    end

    // watchdog: any handshake on any channel counts as progress
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < MAX_SITES; i++) begin
            seed_bank[i] = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset table: all seeds at the origin, black, so everything ties on seed 0
        queue_pixel(0, 0);
        queue_pixel(1023, 511);
        queue_pixel(767, 511);
        queue_pixel(512, 256);
        wait_idle();

        // hand-placed table: corners, a duplicated seed, a symmetric pair
        write_seed(0, seed_at(0,   0,    0,   0,   0));
        write_seed(1, seed_at(1,   1,    255, 0,   0));
        write_seed(2, seed_at(511, 1023, 0,   255, 0));
        write_seed(3, seed_at(511, 1023, 0,   0,   255));   // same spot as seed 2
        write_seed(4, seed_at(200, 300,  255, 255, 255));
        write_seed(5, seed_at(300, 200,  17,  34,  51));
        write_seed(6, seed_at(0,   767,  128, 64,  32));
        write_seed(7, seed_at(511, 0,    1,   2,   3));
        // out-of-table writes must leave the table alone
        write_seed(FIRST_SPARE_REG, '1);
        write_seed(LAST_SPARE_REG, '1);
        cfg_valid <= 1'b0;
        queue_pixel(0, 0);
        queue_pixel(1, 1);
        queue_pixel(1023, 511);     // exact tie between seeds 2 and 3
        queue_pixel(767, 0);
        queue_pixel(0, 511);
        queue_pixel(300, 200);
        queue_pixel(200, 300);
        queue_pixel(250, 250);      // equidistant from seeds 4 and 5
        queue_pixel(1023, 0);
        queue_pixel(512, 255);
        wait_idle();

        // clustered table: far pixels saturate on every seed and tie on seed 0
        write_seed(0, seed_at(0, 0, 10, 20, 30));
        write_seed(1, seed_at(1, 1, 40, 50, 60));
        for (int i = 2; i < MAX_SITES; i++) begin
            write_seed(CFG_IDX_W'(i), seed_at(i % 4, 3 - i % 4, 7 * i, 11 * i, 13 * i));
        end
        cfg_valid <= 1'b0;
        queue_pixel(1023, 511);
        queue_pixel(1000, 500);
        queue_pixel(0, 0);
        wait_idle();

        // random part; the second phase holds the sink off with the source
        // running flat out, so the pipe fills and s_tready drops
        run_phase(SEEDS_IMAGE,    300, 1'b1, 1'b0);
        run_phase(SEEDS_RANDOM,   250, 1'b0, 1'b1);
        run_phase(SEEDS_CLUSTER,  250, 1'b1, 1'b0);
        run_phase(SEEDS_SAME,     150, 1'b1, 1'b0);
        run_phase(SEEDS_ALL_ONES, 150, 1'b1, 1'b0);
        run_phase(SEEDS_IMAGE,    250, 1'b0, 1'b0);
        run_phase(SEEDS_ZERO,     100, 1'b1, 1'b0);
        run_phase(SEEDS_RANDOM,   300, 1'b1, 1'b0);

        // catch stray results after the last expected one
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0 && color_due_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/nsp_pkg.sv
rtl/nearest_seed_pixel_color.sv
tb/tb_nearest_seed_pixel_color.sv
